FILE: hw/rtl/rrkg_pkg.sv
// package: types, constants and helper functions of the rijndael round key generator
`default_nettype none

package rrkg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned SelW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned WinDepth = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [SelW-1:0]  sel_t;
  typedef logic [3:0]       nwords_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_GEN  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_KEY_SIZE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE = 1'b1;

  localparam sel_t SEL_128 = 2'd0;
  localparam sel_t SEL_192 = 2'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] RCON_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // words per key or block: 4, 6 or 8 (selector three counts as 8)
  function automatic nwords_t size_words(input sel_t sel);
    nwords_t n;
    case (sel)
      SEL_128: n = 4'd4;
      SEL_192: n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // schedule length nb * (max(nk, nb) + 7)
  function automatic idx_t total_words(input sel_t ksel, input sel_t bsel);
    nwords_t nk;
    nwords_t nb;
    nwords_t nmax;
    logic [7:0] prod;
    nk   = size_words(ksel);
    nb   = size_words(bsel);
    nmax = (nk > nb) ? nk : nb;
    prod = {4'd0, nb} * ({4'd0, nmax} + 8'd7);
    return prod[IdxW-1:0];
  endfunction

  function automatic word_t sbox_subst(input word_t w);
    word_t r;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = SBOX[w[8*k +: 8]];
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? RCON_POLY : 8'h00);
  endfunction

  // true when i is a multiple of six, via reciprocal multiply and one correction
  function automatic logic is_mult6(input idx_t i);
    logic [12:0] prod;
    logic [4:0]  q;
    logic [7:0]  q6;
    logic [7:0]  r;
    prod = {6'd0, i} * 13'd43;
    q    = prod[12:8];
    q6   = {3'd0, q} * 8'd6;
    r    = {1'b0, i} - q6;
    return (r == 8'd0) || (r == 8'd6);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrkg_req_if.sv
// interface: request channel carrying key loads and generate commands
`default_nettype none

interface rrkg_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  rrkg_pkg::word_t      key_word;

  modport source (output valid, output req_type, output key_word, input ready);
  modport sink   (input valid, input req_type, input key_word, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rrkg_rsp_if.sv
// interface: result channel carrying round key words and status
`default_nettype none

interface rrkg_rsp_if;
  logic                 valid;
  logic                 ready;
  rrkg_pkg::word_t      round_key_word;
  rrkg_pkg::idx_t       word_index;
  logic                 last_word;
  logic                 status;

  modport source (output valid, output round_key_word, output word_index,
                  output last_word, output status, input ready);
  modport sink   (input valid, input round_key_word, input word_index,
                  input last_word, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rijndael_round_key_generator_core.sv
// top level: on-the-fly rijndael key schedule, one word per request
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      req_type, key_word
//   rsp      out  valid/ready      round_key_word, word_index, last_word, status
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_wdata_i (key / block size select)
//
// two register stages: an input register and a result register
// a request moves on to the result register; one request per cycle while rsp is ready
// the word window and round constant update when a request moves to the result register
// reset clears the window, the word count and the size selects, and sets the round constant to 01
// a stalled result holds and an empty input register still takes one more request
`default_nettype none

module rijndael_round_key_generator_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  rrkg_req_if.sink                        req,
  rrkg_rsp_if.source                      rsp,
  input  wire                             cfg_we_i,
  input  wire [rrkg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [rrkg_pkg::SelW-1:0]        cfg_wdata_i
);

  rrkg_pkg::sel_t  key_sel_q;
  rrkg_pkg::sel_t  blk_sel_q;

  logic            in_valid_q;
  logic            in_type_q;
  rrkg_pkg::word_t in_word_q;

  rrkg_pkg::word_t win_q [rrkg_pkg::WinDepth];
  rrkg_pkg::idx_t  done_q;
  logic [7:0]      rcon_q;

  logic            out_valid_q;
  rrkg_pkg::word_t out_word_q;
  rrkg_pkg::idx_t  out_idx_q;
  logic            out_last_q;
  logic            out_status_q;

  logic            out_adv;
  logic            in_adv;
  logic            req_fire;

  rrkg_pkg::nwords_t nk;
  rrkg_pkg::idx_t    nk_w;
  rrkg_pkg::idx_t    total;
  rrkg_pkg::word_t   prev_word;
  rrkg_pkg::word_t   back_word;
  rrkg_pkg::word_t   rotl_prev;
  rrkg_pkg::word_t   t_word;
  rrkg_pkg::word_t   gen_word;
  logic              pos_zero;
  logic              pos_four;
  logic              gen_ok;
  logic              restart;
  logic              shift_en;

  rrkg_pkg::word_t   res_word;
  rrkg_pkg::idx_t    res_idx;
  logic              res_last;
  logic              res_status;
  rrkg_pkg::word_t   new_word;
  rrkg_pkg::idx_t    done_d;
  logic [7:0]        rcon_d;

  assign out_adv   = !out_valid_q || rsp.ready;
  assign in_adv    = in_valid_q && out_adv;
  assign req.ready = !in_valid_q || out_adv;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid          = out_valid_q;
  assign rsp.round_key_word = out_word_q;
  assign rsp.word_index     = out_idx_q;
  assign rsp.last_word      = out_last_q;
  assign rsp.status         = out_status_q;

  always_comb begin
    nk        = rrkg_pkg::size_words(key_sel_q);
    nk_w      = {3'd0, nk};
    total     = rrkg_pkg::total_words(key_sel_q, blk_sel_q);
    prev_word = win_q[0];
    case (key_sel_q)
      rrkg_pkg::SEL_128: back_word = win_q[3];
      rrkg_pkg::SEL_192: back_word = win_q[5];
      default:           back_word = win_q[7];
    endcase
    case (key_sel_q)
      rrkg_pkg::SEL_128: pos_zero = (done_q[1:0] == 2'd0);
      rrkg_pkg::SEL_192: pos_zero = rrkg_pkg::is_mult6(done_q);
      default:           pos_zero = (done_q[2:0] == 3'd0);
    endcase
    pos_four  = (nk > 4'd6) && (done_q[2:0] == 3'd4);
    rotl_prev = {prev_word[23:0], prev_word[31:24]};
    if (pos_zero) begin
      t_word = rrkg_pkg::sbox_subst(rotl_prev) ^ {rcon_q, 24'd0};
    end else if (pos_four) begin
      t_word = rrkg_pkg::sbox_subst(prev_word);
    end else begin
      t_word = prev_word;
    end
    gen_word = t_word ^ back_word;
    gen_ok   = (done_q >= nk_w) && (done_q < total);
    restart  = (done_q >= nk_w);

    res_word   = '0;
    res_idx    = '0;
    res_last   = 1'b0;
    res_status = rrkg_pkg::STATUS_OK;
    new_word   = in_word_q;
    done_d     = done_q;
    rcon_d     = rcon_q;
    shift_en   = 1'b0;
    if (in_type_q == rrkg_pkg::REQ_LOAD) begin
      shift_en = 1'b1;
      res_word = in_word_q;
      if (restart) begin
        res_idx = '0;
        rcon_d  = rrkg_pkg::RCON_INIT;
      end else begin
        res_idx = done_q;
      end
      done_d = res_idx + 7'd1;
    end else if (gen_ok) begin
      shift_en = 1'b1;
      new_word = gen_word;
      res_word = gen_word;
      res_idx  = done_q;
      res_last = (done_q + 7'd1) == total;
      done_d   = done_q + 7'd1;
      if (pos_zero) begin
        rcon_d = rrkg_pkg::xtime(rcon_q);
      end
    end else begin
      res_status = rrkg_pkg::STATUS_REFUSED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sel_q <= '0;
      blk_sel_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrkg_pkg::CFG_KEY_SIZE:   key_sel_q <= cfg_wdata_i;
        rrkg_pkg::CFG_BLOCK_SIZE: blk_sel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.ready) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_type_q <= req.req_type;
      in_word_q <= req.key_word;
    end
  end

  // newest word in entry 0, word i-k-1 in entry k
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rrkg_pkg::WinDepth; k++) begin
        win_q[k] <= '0;
      end
      done_q <= '0;
      rcon_q <= rrkg_pkg::RCON_INIT;
    end else if (in_adv) begin
      if (shift_en) begin
        win_q[0] <= new_word;
        for (int k = 1; k < rrkg_pkg::WinDepth; k++) begin
          win_q[k] <= win_q[k-1];
        end
      end
      done_q <= done_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_word_q   <= res_word;
      out_idx_q    <= res_idx;
      out_last_q   <= res_last;
      out_status_q <= res_status;
    end
  end

endmodule

`default_nettype wire
